// ===== hdl/scfc_pkg.sv =====
package scfc_pkg;

  localparam int MAX_FRAME   = 16;
  localparam int COUNT_W     = 7;
  localparam int SUM_MOD     = 1000;
  localparam int SUM_W       = 10;
  localparam int DIGIT_COUNT = 3;
  localparam int OVERHEAD    = 3 + 4;

  localparam logic [7:0] SYNC_RESET = 8'd33;
  localparam logic [7:0] END_RESET  = 8'd35;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    REG_SYNC = 2'd0,
    REG_END  = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CMD   = 2'd1,
    ST_BAD_FRAME = 2'd2,
    ST_BAD_SUM   = 2'd3
  } status_t;

  typedef struct packed {
    logic             hit;
    logic [2:0]       payload_len;
  } cmd_info_t;

  // Frame context handed to the verdict logic.
  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic               overflowed;
    logic [SUM_W-1:0]   sum_mod;
    logic [7:0]         digit0;
    logic [7:0]         digit1;
    logic [7:0]         digit2;
    logic [7:0]         command;
  } frame_t;

  function automatic cmd_info_t cmd_lookup(input logic [7:0] c);
    cmd_info_t info;
    info.hit = 1'b1;
    case (c)
      8'h30:   info.payload_len = 3'd2;
      8'h31:   info.payload_len = 3'd4;
      8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37:
               info.payload_len = 3'd0;
      8'h41:   info.payload_len = 3'd4;
      8'h42:   info.payload_len = 3'd4;
      8'h43:   info.payload_len = 3'd3;
      8'h44:   info.payload_len = 3'd3;
      8'h45:   info.payload_len = 3'd3;
      8'h5A:   info.payload_len = 3'd2;
      default: begin
        info.hit         = 1'b0;
        info.payload_len = 3'd0;
      end
    endcase
    return info;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// ===== hdl/serial_command_frame_checker.sv =====
// A closing byte is held in the input register, then its verdict is loaded into the result register.
// Throughput: one byte per cycle; the input stage stalls only while a verdict
// waits in the output register and out_ready is low.
// Reset (synchronous, active high): sync/end bytes return to '!'/'#', frame state
// clears, no result pending. The configuration channel is always ready.
module serial_command_frame_checker
  import scfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] command_code,
  output logic [7:0] sender_id,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0]         sync_byte;
  logic [7:0]         end_byte;

  logic               held;
  logic [7:0]         held_byte;

  logic               in_frame;
  logic [COUNT_W-1:0] byte_count;
  logic               overflowed;
  logic [SUM_W-1:0]   sum_mod;
  logic [7:0]         recent [DIGIT_COUNT];
  logic [7:0]         held_command;
  logic [7:0]         held_sender;

  logic               is_sync;
  logic               is_end;
  logic               emit;
  logic               advance;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_next;
  frame_t             frame;
  status_t            verdict;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SYNC_RESET;
      end_byte  <= END_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SYNC: sync_byte <= cfg_data;
        REG_END:  end_byte  <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign is_sync = held_byte == sync_byte;
  assign is_end  = held_byte == end_byte;
  assign emit    = held && !is_sync && in_frame && is_end;
  assign advance = held && (!emit || !out_valid || out_ready);
  assign in_ready = !held || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= rx_byte;
    end
  end

  // checksum kept mod 1000 as bytes leave the digit window
  assign sum_wide = (SUM_W + 1)'(sum_mod) + (SUM_W + 1)'(recent[0]);
  assign sum_next = (sum_wide >= (SUM_W + 1)'(SUM_MOD)) ?
                    SUM_W'(sum_wide - (SUM_W + 1)'(SUM_MOD)) : SUM_W'(sum_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      byte_count   <= '0;
      overflowed   <= 1'b0;
      sum_mod      <= '0;
      recent[0]    <= '0;
      recent[1]    <= '0;
      recent[2]    <= '0;
      held_command <= '0;
      held_sender  <= '0;
    end else if (advance) begin
      if (is_sync) begin
        in_frame     <= 1'b1;
        byte_count   <= COUNT_W'(1);
        overflowed   <= 1'b0;
        sum_mod      <= '0;
        recent[0]    <= '0;
        recent[1]    <= '0;
        recent[2]    <= '0;
        held_command <= '0;
        held_sender  <= '0;
      end else if (in_frame) begin
        if (is_end) begin
          in_frame <= 1'b0;
        end else if (byte_count >= COUNT_W'(MAX_FRAME - 1)) begin
          overflowed <= 1'b1;
        end else begin
          if (byte_count == COUNT_W'(1)) begin
            held_sender <= held_byte;
          end
          if (byte_count == COUNT_W'(2)) begin
            held_command <= held_byte;
          end
          sum_mod    <= sum_next;
          recent[0]  <= recent[1];
          recent[1]  <= recent[2];
          recent[2]  <= held_byte;
          byte_count <= byte_count + COUNT_W'(1);
        end
      end
    end
  end

  assign frame.byte_count = byte_count;
  assign frame.overflowed = overflowed;
  assign frame.sum_mod    = sum_mod;
  assign frame.digit0     = recent[0];
  assign frame.digit1     = recent[1];
  assign frame.digit2     = recent[2];
  assign frame.command    = held_command;

  scfc_verdict u_verdict (
    .frame  (frame),
    .status (verdict)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      status       <= verdict;
      command_code <= held_command;
      sender_id    <= held_sender;
    end
  end

  a_close_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> (!in_frame && out_valid))
    else $error("frame still open after verdict");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (byte_count <= COUNT_W'(MAX_FRAME - 1) && byte_count != '0))
    else $error("byte count out of range");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    sum_mod < SUM_W'(SUM_MOD))
    else $error("checksum accumulator not reduced");

  a_ok_known_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> cmd_lookup(command_code).hit)
    else $error("ok verdict for unknown command");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!in_frame && !out_valid && !held))
    else $error("state not cleared by reset");

endmodule

// ===== hdl/scfc_verdict.sv =====
module scfc_verdict
  import scfc_pkg::*;
(
  input  frame_t  frame,
  output status_t status
);

  cmd_info_t          info;
  logic [COUNT_W-1:0] expect_count;
  logic [3:0]         d0;
  logic [3:0]         d1;
  logic [3:0]         d2;
  logic [SUM_W-1:0]   given;
  logic               digits_ok;

  assign info = cmd_lookup(frame.command);
  // count excludes the end byte, so a good frame has OVERHEAD-1 + payload bytes
  assign expect_count = COUNT_W'(OVERHEAD - 1) + COUNT_W'(info.payload_len);

  assign d0 = 4'(frame.digit0 - CHAR_ZERO);
  assign d1 = 4'(frame.digit1 - CHAR_ZERO);
  assign d2 = 4'(frame.digit2 - CHAR_ZERO);
  assign given = SUM_W'(d0) * SUM_W'(100) + SUM_W'(d1) * SUM_W'(10) + SUM_W'(d2);
  assign digits_ok = is_digit(frame.digit0) && is_digit(frame.digit1) &&
                     is_digit(frame.digit2);

  always_comb begin
    if (!info.hit) begin
      status = ST_BAD_CMD;
    end else if (frame.overflowed || frame.byte_count != expect_count) begin
      status = ST_BAD_FRAME;
    end else if (!digits_ok || given != frame.sum_mod) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_OK;
    end
  end

endmodule

// ===== tb/sv/serial_command_frame_checker_test.sv =====
module serial_command_frame_checker_test;
  import scfc_pkg::*;

  localparam int LATENCY_PAUSE = 4;
  localparam int STALL_LIMIT   = 1000;

  typedef struct packed {
    status_t    status;
    logic [7:0] command;
    logic [7:0] sender;
  } verdict_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       pinned;
    verdict_t   verdict;
  } stim_row_t;

  typedef enum int {
    FR_GOOD, FR_CHECKSUM, FR_LENGTH, FR_UNKNOWN, FR_SHORT, FR_RESTART, FR_NOISE
  } frame_kind_t;

  localparam logic [7:0] CMD_CODES [14] = '{
    "0", "1", "2", "3", "4", "5", "6", "7", "A", "B", "C", "D", "E", "Z"
  };
  localparam int CMD_LENS [14] = '{2, 4, 0, 0, 0, 0, 0, 0, 4, 4, 3, 3, 3, 2};

  localparam verdict_t NONE = '{ST_OK, 8'h00, 8'h00};

  localparam stim_row_t DIRECTED [25] = '{
    // too short for its command
    '{"!", 1'b0, NONE}, '{"1", 1'b0, NONE}, '{"2", 1'b0, NONE},
    '{"#", 1'b1, '{ST_BAD_FRAME, "2", "1"}},
    // closed right after sync: no command, no sender
    '{"!", 1'b0, NONE},
    '{"#", 1'b1, '{ST_BAD_CMD, 8'h00, 8'h00}},
    // 'X' + '2' = 138
    '{"!", 1'b0, NONE}, '{"X", 1'b0, NONE}, '{"2", 1'b0, NONE},
    '{"1", 1'b0, NONE}, '{"3", 1'b0, NONE}, '{"8", 1'b0, NONE},
    '{"#", 1'b1, '{ST_OK, "2", "X"}},
    '{"!", 1'b0, NONE}, '{8'hFF, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
    '{"#", 1'b1, '{ST_BAD_CMD, 8'h00, 8'hFF}},
    // end byte with no frame open
    '{"#", 1'b0, NONE},
    '{"!", 1'b0, NONE}, '{"X", 1'b0, NONE}, '{"2", 1'b0, NONE},
    '{"1", 1'b0, NONE}, '{"3", 1'b0, NONE}, '{"9", 1'b0, NONE},
    '{"#", 1'b1, '{ST_BAD_SUM, "2", "X"}}
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] status;
  logic [7:0] command_code;
  logic [7:0] sender_id;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_SYNC;
  logic [7:0] cfg_data  = 8'h00;

  // checker model state
  logic [7:0]  sync_val;
  logic [7:0]  end_val;
  logic        frame_open;
  logic [6:0]  frame_len;
  logic        frame_over;
  logic [13:0] frame_sum;
  logic [7:0]  window [3];
  logic [7:0]  frame_cmd;
  logic [7:0]  frame_sender;

  verdict_t    expected_verdicts [$];
  stim_row_t   byte_notes [$];
  verdict_t    oldest;
  int          mismatches     = 0;
  int          stalled_cycles = 0;
  int          ready_left     = 0;

  // stimulus side
  logic [7:0]  cur_sync;
  logic [7:0]  cur_end;
  logic [7:0]  frame_q [$];
  int          bytes_sent = 0;

  serial_command_frame_checker DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .command_code (command_code),
    .sender_id    (sender_id),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int cmd_slot(input logic [7:0] c);
    foreach (CMD_CODES[i]) begin
      if (CMD_CODES[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic bit numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void open_frame();
    frame_len    = 7'd1;
    frame_over   = 1'b0;
    frame_sum    = '0;
    frame_cmd    = 8'h00;
    frame_sender = 8'h00;
    foreach (window[i]) window[i] = 8'h00;
  endfunction

  function automatic status_t frame_verdict();
    int slot;
    int total;
    int given;
    slot  = cmd_slot(frame_cmd);
    total = int'(frame_len) + 1;
    if (slot < 0) return ST_BAD_CMD;
    if (frame_over || total < OVERHEAD || total - OVERHEAD != CMD_LENS[slot])
      return ST_BAD_FRAME;
    if (!numeral(window[0]) || !numeral(window[1]) || !numeral(window[2]))
      return ST_BAD_SUM;
    given = (int'(window[0]) - int'(CHAR_ZERO)) * 100 +
            (int'(window[1]) - int'(CHAR_ZERO)) * 10 +
            (int'(window[2]) - int'(CHAR_ZERO));
    if (given != int'(frame_sum) % SUM_MOD) return ST_BAD_SUM;
    return ST_OK;
  endfunction

  function automatic void track_byte(input logic [7:0] b, input stim_row_t note);
    verdict_t v;
    if (b == sync_val) begin
      open_frame();
      frame_open = 1'b1;
    end else if (frame_open) begin
      if (b == end_val) begin
        v.status  = frame_verdict();
        v.command = frame_cmd;
        v.sender  = frame_sender;
        expected_verdicts.push_back(note.pinned ? note.verdict : v);
        frame_open = 1'b0;
      end else if (frame_len >= MAX_FRAME - 1) begin
        frame_over = 1'b1;
      end else begin
        if (frame_len == 7'd1) frame_sender = b;
        else if (frame_len == 7'd2) frame_cmd = b;
        // bytes leaving the three-byte window are the summed ones
        frame_sum = frame_sum + window[0];
        window[0] = window[1];
        window[1] = window[2];
        window[2] = b;
        frame_len = frame_len + 7'd1;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sync_val   = SYNC_RESET;
      end_val    = END_RESET;
      open_frame();
      frame_open = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC: sync_val = cfg_data;
          REG_END:  end_val  = cfg_data;
          default: ;
        endcase
      end
      // one note per rx transaction, popped when the byte is taken
      if (in_valid && in_ready) track_byte(rx_byte, byte_notes.pop_front());
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: status %0d command %h sender %h",
                   $time, status, command_code, sender_id);
        end else begin
          oldest = expected_verdicts.pop_front();
          if (status !== oldest.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, oldest.status, status);
          end
          if (command_code !== oldest.command) begin
            mismatches++;
            $display("%0t: command_code expected %h actual %h",
                     $time, oldest.command, command_code);
          end
          if (sender_id !== oldest.sender) begin
            mismatches++;
            $display("%0t: sender_id expected %h actual %h", $time, oldest.sender, sender_id);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == STALL_LIMIT) begin
      $display("** serial_command_frame_checker: FAILED **");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_left <= 0;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (!out_ready) begin
      out_ready  <= 1'b1;
      // now and then a long stretch with the sink always ready
      ready_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 20);
    end else begin
      out_ready  <= 1'b0;
      ready_left <= pick_gap();
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == cur_sync || b == cur_end);
    return b;
  endfunction

  function automatic void build_frame(input frame_kind_t kind);
    int slot;
    int len;
    int sum;
    int pos;
    bit bad_char;
    logic [7:0] cmd;
    logic [7:0] sender;
    logic [7:0] b;
    frame_q.delete();
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind == FR_RESTART) begin
      frame_q.push_back(cur_sync);
      repeat ($urandom_range(0, 8)) frame_q.push_back(plain_byte());
    end
    slot = $urandom_range(0, 13);
    cmd  = CMD_CODES[slot];
    len  = CMD_LENS[slot];
    if (kind == FR_UNKNOWN) begin
      do cmd = plain_byte(); while (cmd_slot(cmd) >= 0);
      len = $urandom_range(0, 6);
    end else if (kind == FR_LENGTH) begin
      // long ones run past the maximum frame
      do len = $urandom_range(0, 14); while (len == CMD_LENS[slot]);
    end
    sender = plain_byte();
    frame_q.push_back(cur_sync);
    frame_q.push_back(sender);
    frame_q.push_back(cmd);
    sum = int'(sender) + int'(cmd);
    repeat (len) begin
      b = plain_byte();
      frame_q.push_back(b);
      sum += int'(b);
    end
    sum %= SUM_MOD;
    bad_char = (kind == FR_CHECKSUM) && ($urandom_range(0, 1) == 1);
    if (kind == FR_CHECKSUM && !bad_char) sum = (sum + $urandom_range(1, 999)) % SUM_MOD;
    frame_q.push_back(8'(int'(CHAR_ZERO) + sum / 100));
    frame_q.push_back(8'(int'(CHAR_ZERO) + sum / 10 % 10));
    frame_q.push_back(8'(int'(CHAR_ZERO) + sum % 10));
    if (bad_char) begin
      pos = frame_q.size() - 1 - $urandom_range(0, 2);
      do b = plain_byte(); while (numeral(b));
      frame_q[pos] = b;
    end
    if (kind == FR_SHORT) begin
      pos = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > pos) void'(frame_q.pop_back());
    end
    frame_q.push_back(cur_end);
  endfunction

  task automatic send_byte(input stim_row_t row, input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_notes.push_back(row);
    in_valid <= 1'b1;
    rx_byte  <= row.rx;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic run_frames(input int budget);
    int start;
    int r;
    int i;
    bit steady;
    frame_kind_t kind;
    stim_row_t row;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 55)      kind = FR_GOOD;
      else if (r < 65) kind = FR_CHECKSUM;
      else if (r < 73) kind = FR_LENGTH;
      else if (r < 80) kind = FR_UNKNOWN;
      else if (r < 86) kind = FR_SHORT;
      else if (r < 92) kind = FR_RESTART;
      else             kind = FR_NOISE;
      build_frame(kind);
      steady = ($urandom_range(0, 4) == 0);
      for (i = 0; i < frame_q.size(); i++) begin
        row.rx      = frame_q[i];
        row.pinned  = 1'b0;
        row.verdict = NONE;
        send_byte(row, steady);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_verdicts.size() != 0);
    repeat (LATENCY_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
    write_reg(REG_SYNC, s);
    write_reg(REG_END, e);
    cfg_valid <= 1'b0;
    cur_sync = s;
    cur_end  = e;
  endtask

  initial begin
    cur_sync = SYNC_RESET;
    cur_end  = END_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) send_byte(DIRECTED[i], 1'b0);
    settle();
    set_markers(SYNC_RESET, END_RESET);
    run_frames(310);
    settle();
    set_markers(8'h00, 8'hFF);
    run_frames(310);
    settle();
    set_markers(8'hFF, 8'h00);
    run_frames(310);
    settle();
    // sync equal to end: every frame restarts, nothing closes
    set_markers(8'h40, 8'h40);
    run_frames(80);
    settle();
    set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_frames(310);
    settle();
    set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_frames(310);
    settle();
    if (mismatches == 0) begin
      $display("** serial_command_frame_checker: PASSED **");
    end else begin
      $display("** serial_command_frame_checker: FAILED **");
    end
    $finish;
  end

endmodule
